/* hw/rtl/lts_pkg.sv */
// Shared types and codes for the loop-track sequencer.
`default_nettype none

package lts_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_START = 2'd2,
    CMD_RESET = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_RECORD  = 3'd1,
    MODE_PLAY    = 3'd2,
    MODE_WAIT    = 3'd3,
    MODE_STOPPED = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    LED_KEEP  = 2'd0,
    LED_ON    = 2'd1,
    LED_OFF   = 2'd2,
    LED_FLASH = 2'd3
  } led_e;

  localparam logic [1:0] STAGE_NONE    = 2'd0;
  localparam logic [1:0] STAGE_RUNNING = 2'd1;

  localparam int unsigned InDataW  = 8;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 16;

  // Packed so that mode_now lands in the lowest bits.
  typedef struct packed {
    logic  advance_stage;
    logic  latch_length;
    logic  rewind_position;
    led_e  green_led_cmd;
    led_e  red_led_cmd;
    logic  end_play;
    logic  begin_play;
    logic  end_record;
    logic  begin_record;
    mode_e mode_now;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);

endpackage

`default_nettype wire

/* hw/rtl/looper_track_sequencer.sv */
// Loop-track sequencer: mode controller for one looper track.
`default_nettype none

// One track's mode controller (idle, recording, playing, waiting, stopped).
// Each input transfer carries one command in tuser (tick, stop, start, reset)
// and the tick qualifiers in tdata; each input transfer yields exactly one
// result transfer with the new mode, the track start/stop strobes, the last
// LED command of the step and the first-take stage actions. The mode logic is
// combinational: a command accepted at one edge has its result on the output
// register after that edge, and a new command is taken every cycle as long as
// the output register is empty or is being drained in the same cycle.
module looper_track_sequencer (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  // [0] button_fell, [1] record_mode, [2] loop_wrapped, [4:3] first_take_stage
  input  wire  [lts_pkg::InDataW-1:0]  s_axis_tdata,
  // [1:0] cmd
  input  wire  [lts_pkg::InUserW-1:0]  s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  // [2:0] mode_now, [3] begin_record, [4] end_record, [5] begin_play,
  // [6] end_play, [8:7] red_led_cmd, [10:9] green_led_cmd,
  // [11] rewind_position, [12] latch_length, [13] advance_stage
  output logic [lts_pkg::OutDataW-1:0] m_axis_tdata
);
  import lts_pkg::*;

  mode_e   mode_q, mode_d;
  mode_e   saved_q, saved_d;
  logic    pstop_q, pstop_d;
  logic    pplay_q, pplay_d;
  logic    out_valid_q, out_valid_d;
  result_t res_q, res_d;

  logic       in_xfer;
  cmd_e       cmd;
  logic       press, rec, wrap;
  logic [1:0] stage;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  assign cmd   = cmd_e'(s_axis_tuser[1:0]);
  assign press = s_axis_tdata[0];
  assign rec   = s_axis_tdata[1];
  assign wrap  = s_axis_tdata[2];
  assign stage = s_axis_tdata[4:3];

  always_comb begin
    res_d   = '0;
    mode_d  = mode_q;
    saved_d = saved_q;
    pstop_d = pstop_q;
    pplay_d = pplay_q;

    unique case (cmd)
      CMD_TICK: begin
        // Arming a pending request; it may fire in this same tick on a wrap.
        if (mode_q == MODE_PLAY && press && !rec) begin
          res_d.green_led_cmd = LED_FLASH;
          pstop_d             = 1'b1;
        end
        if (mode_q == MODE_WAIT && press && !rec) begin
          res_d.green_led_cmd = LED_FLASH;
          pplay_d             = 1'b1;
        end
        unique case (mode_q)
          MODE_IDLE: begin
            if (press && (stage == STAGE_NONE || rec)) begin
              res_d.begin_record  = 1'b1;
              res_d.begin_play    = 1'b1;
              res_d.red_led_cmd   = LED_ON;
              res_d.green_led_cmd = LED_ON;
              mode_d              = MODE_RECORD;
              if (stage == STAGE_NONE) begin
                res_d.rewind_position = 1'b1;
                res_d.advance_stage   = 1'b1;
              end
            end
          end
          MODE_RECORD: begin
            if (press) begin
              res_d.end_record  = 1'b1;
              res_d.red_led_cmd = LED_OFF;
              mode_d            = MODE_PLAY;
              if (stage == STAGE_RUNNING) begin
                res_d.latch_length  = 1'b1;
                res_d.advance_stage = 1'b1;
              end
            end
          end
          MODE_PLAY: begin
            if (pstop_d && wrap) begin
              res_d.end_play      = 1'b1;
              res_d.green_led_cmd = LED_OFF;
              mode_d              = MODE_WAIT;
              pstop_d             = 1'b0;
            end
            if (press && rec) begin
              res_d.begin_record = 1'b1;
              res_d.red_led_cmd  = LED_ON;
              mode_d             = MODE_RECORD;
            end
          end
          MODE_WAIT: begin
            if (pplay_d && wrap) begin
              res_d.begin_play    = 1'b1;
              res_d.green_led_cmd = LED_ON;
              mode_d              = MODE_PLAY;
              pplay_d             = 1'b0;
            end
            if (press && rec) begin
              res_d.begin_play    = 1'b1;
              res_d.begin_record  = 1'b1;
              res_d.red_led_cmd   = LED_ON;
              res_d.green_led_cmd = LED_ON;
              mode_d              = MODE_RECORD;
            end
          end
          default: ;
        endcase
      end
      CMD_START: begin
        unique case (saved_q)
          MODE_PLAY: begin
            res_d.begin_play    = 1'b1;
            res_d.green_led_cmd = LED_ON;
            mode_d              = MODE_PLAY;
          end
          MODE_WAIT: mode_d = MODE_WAIT;
          default:   mode_d = MODE_IDLE;
        endcase
      end
      default: begin
        // Stop and reset both halt the current activity.
        if (mode_q == MODE_RECORD) begin
          res_d.end_record    = 1'b1;
          res_d.end_play      = 1'b1;
          res_d.red_led_cmd   = LED_OFF;
          res_d.green_led_cmd = LED_OFF;
        end else if (mode_q == MODE_PLAY) begin
          res_d.end_play      = 1'b1;
          res_d.green_led_cmd = LED_OFF;
        end
        pstop_d = 1'b0;
        pplay_d = 1'b0;
        if (cmd == CMD_STOP) begin
          saved_d = mode_q;
          mode_d  = MODE_STOPPED;
        end else begin
          mode_d = MODE_IDLE;
        end
      end
    endcase

    res_d.mode_now = mode_d;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_xfer) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      saved_q     <= MODE_IDLE;
      pstop_q     <= 1'b0;
      pplay_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_xfer) begin
        mode_q  <= mode_d;
        saved_q <= saved_d;
        pstop_q <= pstop_d;
        pplay_q <= pplay_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - ResultW){1'b0}}, res_q};

endmodule

`default_nettype wire

/* hw/rtl/lts_checker.sv */
// Port-level checker for the loop-track sequencer, bound to the top level.
`default_nettype none

module lts_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          s_axis_tvalid,
  input wire                          s_axis_tready,
  input wire [lts_pkg::InUserW-1:0]   s_axis_tuser,
  input wire                          m_axis_tvalid,
  input wire                          m_axis_tready,
  input wire [lts_pkg::OutDataW-1:0]  m_axis_tdata
);
  import lts_pkg::*;

  logic in_xfer;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // Every accepted command shows its result right after.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> m_axis_tvalid)
    else $error("no result after accepted command");

  // Stalled result must not change.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Reset command lands in idle and never starts the track.
  a_reset_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && s_axis_tuser == CMD_RESET |=>
      m_axis_tdata[2:0] == MODE_IDLE && !m_axis_tdata[3] && !m_axis_tdata[5])
    else $error("reset command did not return to idle");

  // Stop command lands in stopped and never starts the track.
  a_stop_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && s_axis_tuser == CMD_STOP |=>
      m_axis_tdata[2:0] == MODE_STOPPED && !m_axis_tdata[3] && !m_axis_tdata[5])
    else $error("stop command did not enter stopped");

  // A ready input side with a pending result means the result is being taken.
  a_ready_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && s_axis_tready |-> m_axis_tready)
    else $error("input accepted over an undrained result");

endmodule

bind looper_track_sequencer lts_checker u_lts_checker (.*);

`default_nettype wire
